>>> rtl/sobp_pkg.sv
// ----------------------------------------------------------------------------
// Shared object byte parser package
// Phase codes, token kinds, error codes, value type codes, header constants and item and token structs.
// ----------------------------------------------------------------------------
`default_nettype none
package sobp_pkg;

   localparam int unsigned MaxDepth = 8;
   localparam int unsigned QueueDepth = 2;

   typedef enum logic [4:0] {
      PH_HDR, PH_RNAME, PH_PAD, PH_MLEN0, PH_MLEN1, PH_END9, PH_NAME, PH_TYPE,
      PH_FIXED, PH_ALEN, PH_SLEN0, PH_SLEN1, PH_XML0, PH_XLEN0, PH_XLEN1,
      PH_TEXT, PH_DONE, PH_ERR
   } phase_type;

   localparam logic [3:0] TK_HEADER = 4'd0;
   localparam logic [3:0] TK_ROOT   = 4'd1;
   localparam logic [3:0] TK_NLEN   = 4'd2;
   localparam logic [3:0] TK_NAME   = 4'd3;
   localparam logic [3:0] TK_TYPE   = 4'd4;
   localparam logic [3:0] TK_VALUE  = 4'd5;
   localparam logic [3:0] TK_TEXT   = 4'd6;
   localparam logic [3:0] TK_ENDM   = 4'd7;
   localparam logic [3:0] TK_DONE   = 4'd8;
   localparam logic [3:0] TK_ERROR  = 4'd9;

   localparam logic [3:0] ER_NONE   = 4'd0;
   localparam logic [3:0] ER_MAGIC  = 4'd1;
   localparam logic [3:0] ER_TAG    = 4'd2;
   localparam logic [3:0] ER_NLEN   = 4'd3;
   localparam logic [3:0] ER_PAD    = 4'd4;
   localparam logic [3:0] ER_SLEN   = 4'd5;
   localparam logic [3:0] ER_XML    = 4'd6;
   localparam logic [3:0] ER_ENDM   = 4'd7;
   localparam logic [3:0] ER_DEEP   = 4'd8;
   localparam logic [3:0] ER_TRUNC  = 4'd9;

   localparam logic [7:0] TY_NUMBER = 8'h00;
   localparam logic [7:0] TY_BOOL   = 8'h01;
   localparam logic [7:0] TY_STRING = 8'h02;
   localparam logic [7:0] TY_OBJECT = 8'h03;
   localparam logic [7:0] TY_ARRAY  = 8'h08;
   localparam logic [7:0] TY_DATE   = 8'h0B;
   localparam logic [7:0] TY_XML    = 8'h0F;
   localparam logic [7:0] TY_TYPED  = 8'h10;
   localparam logic [7:0] END_MARK  = 8'h09;

   // expected header bytes; length bytes 2..5 are not compared
   function automatic logic [7:0] hdr_expect(input logic [3:0] idx);
      logic [7:0] val;
      begin
         unique case (idx)
            4'd1:    val = 8'hBF;
            4'd6:    val = 8'h54;
            4'd7:    val = 8'h43;
            4'd8:    val = 8'h53;
            4'd9:    val = 8'h4F;
            4'd11:   val = 8'h04;
            default: val = 8'h00;
         endcase
         return val;
      end
   endfunction

   typedef struct packed {
      logic [7:0] byte_val;
      logic       last;
   } item_type;

   typedef struct packed {
      logic [3:0] token_kind;
      logic [7:0] token_byte;
      logic [3:0] nest_depth;
      logic [7:0] value_type;
      logic [3:0] error_code;
      logic       body_done;
   } token_type;

endpackage
`default_nettype wire

>>> rtl/sobp_queue.sv
// ----------------------------------------------------------------------------
// Shared object byte parser input queue
// Two-entry queue between the accepting front and the parsing back end.
// ----------------------------------------------------------------------------
`default_nettype none
module sobp_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push_valid,
   output logic                    push_stall,
   input  wire sobp_pkg::item_type push_item,
   output logic                    pop_valid,
   input  wire logic               pop_ready,
   output sobp_pkg::item_type      pop_item
);
   localparam int unsigned PtrW = $clog2(sobp_pkg::QueueDepth);

   sobp_pkg::item_type mem_ff [sobp_pkg::QueueDepth];
   logic [PtrW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [PtrW:0]   cnt_ff, cnt_in;
   logic push, pop;

   assign push_stall = (cnt_ff == PtrW'(0) + (PtrW+1)'(sobp_pkg::QueueDepth));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_item   = mem_ff[rd_ff];
   assign push = push_valid && !push_stall;
   assign pop  = pop_valid && pop_ready;

   always_comb begin
      wr_in  = push ? wr_ff + PtrW'(1) : wr_ff;
      rd_in  = pop ? rd_ff + PtrW'(1) : rd_ff;
      cnt_in = cnt_ff + (PtrW+1)'(push) - (PtrW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end
endmodule
`default_nettype wire

>>> rtl/sobp_engine.sv
// ----------------------------------------------------------------------------
// Shared object byte parser engine
// Walks header and member records one byte per cycle unless the output is stalled, and registers a token.
// ----------------------------------------------------------------------------
`default_nettype none
module sobp_engine (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire sobp_pkg::item_type in_item,
   output logic                    out_valid,
   input  wire logic               out_stall,
   output sobp_pkg::token_type     out_token
);
   sobp_pkg::phase_type phase_ff, phase_in;
   logic [15:0] cnt_ff, cnt_in;
   logic [31:0] dlen_ff, dlen_in, pos_ff, pos_in;
   logic [3:0]  depth_ff, depth_in, err_ff, err_in;
   logic [7:0]  type_ff, type_in;
   logic        hdr_ok_ff, hdr_ok_in;
   logic        ov_ff;
   sobp_pkg::token_type tok_ff, tok_in;

   logic [31:0] left;
   logic [15:0] dec, len;
   logic [3:0]  kind;
   logic [7:0]  b;
   logic        go;

   assign in_ready  = !ov_ff || !out_stall;
   assign go        = in_valid && in_ready;
   assign out_valid = ov_ff;
   assign out_token = tok_ff;

   assign b    = in_item.byte_val;
   // room left counts the current byte as consumed
   assign left = (dlen_ff > pos_in) ? dlen_ff - pos_in : 32'd0;
   assign dec  = (cnt_ff != 16'd0) ? cnt_ff - 16'd1 : 16'd0;
   assign len  = {cnt_ff[15:8], b};

   always_comb begin
      phase_in  = phase_ff;
      cnt_in    = cnt_ff;
      dlen_in   = dlen_ff;
      pos_in    = pos_ff;
      depth_in  = depth_ff;
      err_in    = err_ff;
      type_in   = type_ff;
      hdr_ok_in = hdr_ok_ff;
      kind      = sobp_pkg::TK_HEADER;

      if (phase_ff == sobp_pkg::PH_ERR) begin
         kind = sobp_pkg::TK_ERROR;
      end else if (phase_ff == sobp_pkg::PH_DONE) begin
         kind = sobp_pkg::TK_DONE;
      end else begin
         if (pos_ff != 32'hFFFF_FFFF) begin
            pos_in = pos_ff + 32'd1;
         end
         unique case (phase_ff)
            sobp_pkg::PH_HDR: begin
               kind = sobp_pkg::TK_HEADER;
               if (pos_ff >= 32'd2 && pos_ff <= 32'd5) begin
                  dlen_in = {dlen_ff[23:0], b};
               end else if (pos_ff < 32'd16) begin
                  if (b != sobp_pkg::hdr_expect(pos_ff[3:0])) begin
                     err_in   = (pos_ff < 32'd2) ? sobp_pkg::ER_MAGIC : sobp_pkg::ER_TAG;
                     phase_in = sobp_pkg::PH_ERR;
                  end
               end else if (pos_ff == 32'd16) begin
                  cnt_in = {b, 8'h00};
               end else begin
                  cnt_in = len;
                  if (len == 16'd0 || 32'(len) > left) begin
                     err_in   = sobp_pkg::ER_NLEN;
                     phase_in = sobp_pkg::PH_ERR;
                  end else begin
                     phase_in = sobp_pkg::PH_RNAME;
                  end
               end
            end
            sobp_pkg::PH_RNAME: begin
               kind   = sobp_pkg::TK_ROOT;
               cnt_in = dec;
               if (dec == 16'd0) begin
                  cnt_in   = 16'd4;
                  phase_in = sobp_pkg::PH_PAD;
               end
            end
            sobp_pkg::PH_PAD: begin
               if (b != 8'h00) begin
                  err_in   = sobp_pkg::ER_PAD;
                  phase_in = sobp_pkg::PH_ERR;
               end else begin
                  cnt_in = dec;
                  if (dec == 16'd0) begin
                     hdr_ok_in = 1'b1;
                     phase_in  = (pos_in >= dlen_ff) ? sobp_pkg::PH_DONE : sobp_pkg::PH_MLEN0;
                  end
               end
            end
            sobp_pkg::PH_MLEN0, sobp_pkg::PH_SLEN0, sobp_pkg::PH_XLEN0: begin
               kind   = (phase_ff == sobp_pkg::PH_MLEN0) ? sobp_pkg::TK_NLEN : sobp_pkg::TK_VALUE;
               cnt_in = {b, 8'h00};
               phase_in = (phase_ff == sobp_pkg::PH_MLEN0) ? sobp_pkg::PH_MLEN1 :
                          (phase_ff == sobp_pkg::PH_SLEN0) ? sobp_pkg::PH_SLEN1 :
                          sobp_pkg::PH_XLEN1;
            end
            sobp_pkg::PH_MLEN1: begin
               kind   = sobp_pkg::TK_NLEN;
               cnt_in = len;
               if (len == 16'd0) begin
                  phase_in = sobp_pkg::PH_END9;
               end else if (32'(len) > left) begin
                  err_in   = sobp_pkg::ER_NLEN;
                  phase_in = sobp_pkg::PH_ERR;
               end else begin
                  phase_in = sobp_pkg::PH_NAME;
               end
            end
            sobp_pkg::PH_END9: begin
               kind = sobp_pkg::TK_ENDM;
               if (b != sobp_pkg::END_MARK) begin
                  err_in   = sobp_pkg::ER_ENDM;
                  phase_in = sobp_pkg::PH_ERR;
               end else begin
                  if (depth_ff != 4'd0) begin
                     depth_in = depth_ff - 4'd1;
                  end
                  phase_in = (pos_in >= dlen_ff) ? sobp_pkg::PH_DONE : sobp_pkg::PH_MLEN0;
               end
            end
            sobp_pkg::PH_NAME: begin
               kind   = sobp_pkg::TK_NAME;
               cnt_in = dec;
               if (dec == 16'd0) begin
                  phase_in = sobp_pkg::PH_TYPE;
               end
            end
            sobp_pkg::PH_TYPE: begin
               kind    = sobp_pkg::TK_TYPE;
               type_in = b;
               unique case (b)
                  sobp_pkg::TY_NUMBER: begin
                     cnt_in = 16'd8; phase_in = sobp_pkg::PH_FIXED;
                  end
                  sobp_pkg::TY_BOOL: begin
                     cnt_in = 16'd1; phase_in = sobp_pkg::PH_FIXED;
                  end
                  sobp_pkg::TY_STRING: phase_in = sobp_pkg::PH_SLEN0;
                  sobp_pkg::TY_OBJECT, sobp_pkg::TY_TYPED: begin
                     if (depth_ff >= 4'(sobp_pkg::MaxDepth)) begin
                        err_in = sobp_pkg::ER_DEEP; phase_in = sobp_pkg::PH_ERR;
                     end else begin
                        depth_in = depth_ff + 4'd1;
                        phase_in = (pos_in >= dlen_ff) ? sobp_pkg::PH_DONE :
                                   sobp_pkg::PH_MLEN0;
                     end
                  end
                  sobp_pkg::TY_ARRAY: begin
                     cnt_in = 16'd4; phase_in = sobp_pkg::PH_ALEN;
                  end
                  sobp_pkg::TY_DATE: begin
                     cnt_in = 16'd10; phase_in = sobp_pkg::PH_FIXED;
                  end
                  sobp_pkg::TY_XML: phase_in = sobp_pkg::PH_XML0;
                  default: phase_in = (pos_in >= dlen_ff) ? sobp_pkg::PH_DONE :
                                      sobp_pkg::PH_MLEN0;
               endcase
            end
            sobp_pkg::PH_FIXED, sobp_pkg::PH_TEXT: begin
               kind   = (phase_ff == sobp_pkg::PH_TEXT) ? sobp_pkg::TK_TEXT : sobp_pkg::TK_VALUE;
               cnt_in = dec;
               if (dec == 16'd0) begin
                  phase_in = (pos_in >= dlen_ff) ? sobp_pkg::PH_DONE : sobp_pkg::PH_MLEN0;
               end
            end
            sobp_pkg::PH_ALEN: begin
               kind   = sobp_pkg::TK_VALUE;
               cnt_in = dec;
               if (dec == 16'd0) begin
                  if (depth_ff >= 4'(sobp_pkg::MaxDepth)) begin
                     err_in = sobp_pkg::ER_DEEP; phase_in = sobp_pkg::PH_ERR;
                  end else begin
                     depth_in = depth_ff + 4'd1;
                     phase_in = (pos_in >= dlen_ff) ? sobp_pkg::PH_DONE : sobp_pkg::PH_MLEN0;
                  end
               end
            end
            sobp_pkg::PH_SLEN1, sobp_pkg::PH_XLEN1: begin
               kind   = sobp_pkg::TK_VALUE;
               cnt_in = len;
               if (len == 16'd0 || 32'(len) > left) begin
                  err_in   = (phase_ff == sobp_pkg::PH_SLEN1) ? sobp_pkg::ER_SLEN :
                             sobp_pkg::ER_XML;
                  phase_in = sobp_pkg::PH_ERR;
               end else begin
                  phase_in = sobp_pkg::PH_TEXT;
               end
            end
            sobp_pkg::PH_XML0: begin
               kind = sobp_pkg::TK_VALUE;
               if (b != 8'h00) begin
                  err_in = sobp_pkg::ER_XML; phase_in = sobp_pkg::PH_ERR;
               end else begin
                  phase_in = sobp_pkg::PH_XLEN0;
               end
            end
            default: begin
               err_in = sobp_pkg::ER_TRUNC; phase_in = sobp_pkg::PH_ERR;
            end
         endcase
      end

      if (in_item.last && phase_in != sobp_pkg::PH_DONE && err_in == sobp_pkg::ER_NONE) begin
         err_in   = sobp_pkg::ER_TRUNC;
         phase_in = sobp_pkg::PH_ERR;
      end
      if (err_in != sobp_pkg::ER_NONE) begin
         kind = sobp_pkg::TK_ERROR;
      end

      tok_in.token_kind = kind;
      tok_in.token_byte = b;
      tok_in.nest_depth = depth_in;
      tok_in.value_type = type_in;
      tok_in.error_code = err_in;
      tok_in.body_done  = hdr_ok_in && (pos_in >= dlen_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= sobp_pkg::PH_HDR;
         cnt_ff    <= '0;
         dlen_ff   <= '0;
         pos_ff    <= '0;
         depth_ff  <= '0;
         err_ff    <= '0;
         type_ff   <= '0;
         hdr_ok_ff <= 1'b0;
         ov_ff     <= 1'b0;
      end else begin
         if (go) begin
            ov_ff <= 1'b1;
            if (in_item.last) begin
               // start a new file after the final byte
               phase_ff  <= sobp_pkg::PH_HDR;
               cnt_ff    <= '0;
               dlen_ff   <= '0;
               pos_ff    <= '0;
               depth_ff  <= '0;
               err_ff    <= '0;
               type_ff   <= '0;
               hdr_ok_ff <= 1'b0;
            end else begin
               phase_ff  <= phase_in;
               cnt_ff    <= cnt_in;
               dlen_ff   <= dlen_in;
               pos_ff    <= pos_in;
               depth_ff  <= depth_in;
               err_ff    <= err_in;
               type_ff   <= type_in;
               hdr_ok_ff <= hdr_ok_in;
            end
         end else if (!out_stall) begin
            ov_ff <= 1'b0;
         end
      end
      if (go) begin
         tok_ff <= tok_in;
      end
   end
endmodule
`default_nettype wire

>>> rtl/shared_object_byte_parser.sv
// ----------------------------------------------------------------------------
// Shared object byte parser
// Classifies each byte of a shared-object file and reports depth and errors.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req_    | in        | req_valid/req_stall | req_in_byte, req_in_last
//  rsp_    | out       | rsp_valid/rsp_stall | token, depth, type, error, done
//
//  One byte per cycle sustained while rsp_stall is low; an accepted byte is
//  written into the queue, then the engine parses it and registers its token,
//  which it offers until the response handshake takes it.
//  The two-entry queue and the engine output register absorb stalls.
//  Synchronous reset returns the parser to the first magic byte.
`default_nettype none
module shared_object_byte_parser (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_in_last,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [3:0]      rsp_token_kind,
   output logic [7:0]      rsp_token_byte,
   output logic [3:0]      rsp_nest_depth,
   output logic [7:0]      rsp_value_type,
   output logic [3:0]      rsp_error_code,
   output logic            rsp_body_done
);
   sobp_pkg::item_type  push_item, pop_item;
   sobp_pkg::token_type tok;
   logic pop_valid, pop_ready;

   assign push_item.byte_val = req_in_byte;
   assign push_item.last     = req_in_last;

   sobp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_stall (req_stall),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   sobp_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pop_valid),
      .in_ready  (pop_ready),
      .in_item   (pop_item),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_token (tok)
   );

   assign rsp_token_kind = tok.token_kind;
   assign rsp_token_byte = tok.token_byte;
   assign rsp_nest_depth = tok.nest_depth;
   assign rsp_value_type = tok.value_type;
   assign rsp_error_code = tok.error_code;
   assign rsp_body_done  = tok.body_done;
endmodule
`default_nettype wire

>>> rtl/sobp_checker.sv
// ----------------------------------------------------------------------------
// Shared object byte parser checker
// Port-level properties of the parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module sobp_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [3:0] rsp_token_kind,
   input wire logic [3:0] rsp_nest_depth,
   input wire logic [3:0] rsp_error_code
);
   // an error code always shows as an error token
   a_err_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code != sobp_pkg::ER_NONE |->
      rsp_token_kind == sobp_pkg::TK_ERROR)
      else $error("error code without error token");

   a_kind_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind == sobp_pkg::TK_ERROR |->
      rsp_error_code != sobp_pkg::ER_NONE)
      else $error("error token without code");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_nest_depth <= 4'(sobp_pkg::MaxDepth))
      else $error("depth beyond limit");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_token_kind))
      else $error("stalled transaction changed");

   a_no_resp_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("activity after reset");
endmodule

bind shared_object_byte_parser sobp_checker u_sobp_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_token_kind (rsp_token_kind),
   .rsp_nest_depth (rsp_nest_depth),
   .rsp_error_code (rsp_error_code)
);
`default_nettype wire
